[src/positional_list_engine_core_assert.svh]
// Assertion macros used by the positional list engine core.
`ifndef POSITIONAL_LIST_ENGINE_CORE_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PLE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("positional list engine: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define PLE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("positional list engine: next-cycle check failed");

`endif

[src/ple_pkg.sv]
// Package with the types and constants of the positional list engine.
package ple_pkg;

    // List geometry.
    localparam int CAPACITY = 64;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    // Compare width that holds a position, a count and a count plus one.
    localparam int CMP_W    = (CNT_W + 1 > 9) ? CNT_W + 1 : 9;

    // Command codes; the fourth code is reserved, leaves the list unchanged and is answered with OK.
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_SEARCH = 2'd2
    } ple_op_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BOUNDS  = 2'd1,
        ST_FULL    = 2'd2,
        ST_MISSING = 2'd3
    } ple_status_t;

    // What a cell loads at the next edge.
    typedef enum logic [1:0] {
        CELL_HOLD       = 2'd0,
        CELL_LOAD       = 2'd1,
        CELL_FROM_LEFT  = 2'd2,
        CELL_FROM_RIGHT = 2'd3
    } ple_cell_op_t;

    // Command transfer payload.
    typedef struct packed {
        ple_op_t            command;
        logic [7:0]         position;
        logic signed [31:0] value;
    } ple_cmd_t;

    // Result transfer payload.
    typedef struct packed {
        ple_status_t status;
        logic [6:0]  found_position;
        logic [6:0]  element_count;
    } ple_rsp_t;

    // Command held between the cell row and the result register.
    typedef struct packed {
        logic             is_search;
        ple_status_t      status;
        logic [CNT_W-1:0] count;
    } ple_stage_t;

endpackage

[src/ple_cell.sv]
// One list cell: holds one entry, shifts with its neighbours and compares with the key.
module ple_cell (
    input  logic                clk,
    input  ple_pkg::ple_cell_op_t op,
    input  logic signed [31:0]  new_value,
    input  logic signed [31:0]  left_value,
    input  logic signed [31:0]  right_value,
    input  logic signed [31:0]  key,
    output logic signed [31:0]  value,
    output logic                match
);

    logic signed [31:0] value_reg;
    logic signed [31:0] value_next;

    // Choose the entry for the next cycle.
    always_comb
    begin
        unique case (op)
            ple_pkg::CELL_HOLD:       value_next = value_reg;
            ple_pkg::CELL_LOAD:       value_next = new_value;
            ple_pkg::CELL_FROM_LEFT:  value_next = left_value;
            ple_pkg::CELL_FROM_RIGHT: value_next = right_value;
            default:                  value_next = value_reg;
        endcase
    end

    // Entry storage; its contents only count below the element count.
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign match = (value_reg == key);

endmodule

[src/ple_first_match.sv]
// Priority encoder that finds the lowest matching cell of the row.
module ple_first_match (
    input  logic [ple_pkg::CAPACITY-1:0] match,
    output logic                         hit,
    output logic [ple_pkg::IDX_W-1:0]    index
);

    // Scan from the top so that the lowest set bit wins.
    always_comb
    begin
        hit   = 1'b0;
        index = '0;
        for (int k = ple_pkg::CAPACITY - 1; k >= 0; k--)
        begin
            if (match[k])
            begin
                hit   = 1'b1;
                index = ple_pkg::IDX_W'(k);
            end
        end
    end

endmodule

[src/positional_list_engine_core.sv]
// Top level of the positional list engine: decode, cell row, search encode and result register.
//
//  Channel | Signals                         | Direction | Payload
//  --------+---------------------------------+-----------+------------------------------
//  cmd     | cmd_valid, cmd_ready, cmd       | in        | command, position, value
//  rsp     | rsp_valid, rsp_ready, rsp       | out       | status, found_position, count
//
// An insert or delete changes the cell row at the edge of its transfer; every cell shifts
// or holds in parallel, and a search compares all cells in that same cycle.
// The match vector is registered in the middle stage and then encoded into the result register,
// and one command is taken per cycle while results are taken.
// A stalled result holds the result register; the middle stage then fills and cmd_ready falls.
// Reset empties the list at once; entries need no clearing, as only counted ones are read.
module positional_list_engine_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  ple_pkg::ple_cmd_t cmd,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output ple_pkg::ple_rsp_t rsp
);

    localparam int CAP = ple_pkg::CAPACITY;
    localparam int CW  = ple_pkg::CMP_W;
    localparam logic [ple_pkg::CNT_W-1:0] CNT_ONE = ple_pkg::CNT_W'(1);

    // Control and payload registers.
    logic [ple_pkg::CNT_W-1:0] count_reg;
    logic [ple_pkg::CNT_W-1:0] count_next;
    logic                      s1_valid_reg;
    logic                      s1_valid_next;
    ple_pkg::ple_stage_t       s1_reg;
    ple_pkg::ple_stage_t       s1_next;
    logic [CAP-1:0]            match_reg;
    logic [CAP-1:0]            match_next;
    logic                      rsp_valid_reg;
    logic                      rsp_valid_next;
    ple_pkg::ple_rsp_t         rsp_reg;
    ple_pkg::ple_rsp_t         rsp_next;

    // Handshake and decode signals.
    logic                      cmd_fire;
    logic                      s1_move;
    logic [CW-1:0]             pos_c;
    logic [CW-1:0]             pos_m1;
    logic [CW-1:0]             cnt_c;
    logic                      do_insert;
    logic                      do_delete;
    logic                      is_search;
    ple_pkg::ple_status_t      dec_status;

    // Cell row wiring.
    ple_pkg::ple_cell_op_t     cell_op [CAP];
    logic signed [31:0]        cell_value [CAP];
    logic [CAP-1:0]            match_raw;
    logic [CAP-1:0]            match_live;

    // Search encode.
    logic                      enc_hit;
    logic [ple_pkg::IDX_W-1:0] enc_index;

    // Transfers and stage movement.
    assign s1_move   = s1_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign cmd_ready = !s1_valid_reg || s1_move;
    assign cmd_fire  = cmd_valid && cmd_ready;

    assign pos_c  = CW'(cmd.position);
    assign pos_m1 = pos_c - CW'(1);
    assign cnt_c  = CW'(count_reg);

    // Command decode and bounds checks.
    always_comb
    begin
        do_insert  = 1'b0;
        do_delete  = 1'b0;
        is_search  = 1'b0;
        dec_status = ple_pkg::ST_OK;
        unique case (cmd.command)
            ple_pkg::OP_INSERT:
            begin
                if (cmd.position == 8'd0 || pos_c > cnt_c + CW'(1))
                    dec_status = ple_pkg::ST_BOUNDS;
                else if (count_reg == ple_pkg::CNT_W'(CAP))
                    dec_status = ple_pkg::ST_FULL;
                else
                    do_insert = 1'b1;
            end
            ple_pkg::OP_DELETE:
            begin
                if (cmd.position == 8'd0 || pos_c > cnt_c)
                    dec_status = ple_pkg::ST_BOUNDS;
                else
                    do_delete = 1'b1;
            end
            ple_pkg::OP_SEARCH:
            begin
                is_search = 1'b1;
            end
            default:
            begin
                dec_status = ple_pkg::ST_OK;
            end
        endcase
    end

    // Element count.
    always_comb
    begin
        count_next = count_reg;
        if (cmd_fire && do_insert)
            count_next = count_reg + ple_pkg::CNT_W'(1);
        else if (cmd_fire && do_delete)
            count_next = count_reg - ple_pkg::CNT_W'(1);
    end

    // The row of cells, each with its own shift control.
    for (genvar k = 0; k < CAP; k++)
    begin : g_cell
        logic signed [31:0] left_v;
        logic signed [31:0] right_v;

        if (k == 0)
        begin : g_first
            assign left_v = cmd.value;
        end
        else
        begin : g_inner_l
            assign left_v = cell_value[k-1];
        end

        if (k == CAP - 1)
        begin : g_last
            assign right_v = '0;
        end
        else
        begin : g_inner_r
            assign right_v = cell_value[k+1];
        end

        always_comb
        begin
            cell_op[k] = ple_pkg::CELL_HOLD;
            if (cmd_fire && do_insert)
            begin
                if (CW'(k) == pos_m1)
                    cell_op[k] = ple_pkg::CELL_LOAD;
                else if (CW'(k) > pos_m1)
                    cell_op[k] = ple_pkg::CELL_FROM_LEFT;
            end
            else if (cmd_fire && do_delete)
            begin
                if (CW'(k) >= pos_m1)
                    cell_op[k] = ple_pkg::CELL_FROM_RIGHT;
            end
        end

        assign match_live[k] = match_raw[k] && (CW'(k) < cnt_c);

        ple_cell u_cell (
            .clk         (clk),
            .op          (cell_op[k]),
            .new_value   (cmd.value),
            .left_value  (left_v),
            .right_value (right_v),
            .key         (cmd.value),
            .value       (cell_value[k]),
            .match       (match_raw[k])
        );
    end

    // Middle stage: decoded result and match vector.
    always_comb
    begin
        s1_valid_next     = s1_valid_reg;
        s1_next           = s1_reg;
        match_next        = match_reg;
        if (s1_move)
            s1_valid_next = 1'b0;
        if (cmd_fire)
        begin
            s1_valid_next     = 1'b1;
            s1_next.is_search = is_search;
            s1_next.status    = dec_status;
            s1_next.count     = count_next;
            match_next        = match_live;
        end
    end

    ple_first_match u_first_match (
        .match (match_reg),
        .hit   (enc_hit),
        .index (enc_index)
    );

    // Result register.
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (rsp_valid_reg && rsp_ready)
            rsp_valid_next = 1'b0;
        if (s1_move)
        begin
            rsp_valid_next         = 1'b1;
            rsp_next.element_count = 7'(s1_reg.count);
            rsp_next.found_position = 7'd0;
            rsp_next.status        = s1_reg.status;
            if (s1_reg.is_search)
            begin
                if (enc_hit)
                begin
                    rsp_next.status         = ple_pkg::ST_OK;
                    rsp_next.found_position =
                        7'({1'b0, enc_index} + (ple_pkg::IDX_W + 1)'(1));
                end
                else
                begin
                    rsp_next.status = ple_pkg::ST_MISSING;
                end
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        s1_reg    <= s1_next;
        match_reg <= match_next;
        rsp_reg   <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Checks on the list bookkeeping.
`include "positional_list_engine_core_assert.svh"

    `PLE_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= ple_pkg::CNT_W'(CAP))
    `PLE_ASSERT_NEXT(a_insert_grows, cmd_fire && do_insert, count_reg == $past(count_reg) + CNT_ONE)
    `PLE_ASSERT_NEXT(a_delete_shrinks, cmd_fire && do_delete, count_reg == $past(count_reg) - CNT_ONE)
    `PLE_ASSERT_NOW(a_ready_when_empty, !s1_valid_reg, cmd_ready)

endmodule
